>>> design/bmap_pkg.sv
// bank mapper package: payload structs, controller/datapath command and status types,
// access codes and address constants; no dependencies
`default_nettype none

package bmap_pkg;

  localparam int unsigned STAMP_BITS_DEF = 16;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 6;

  localparam logic [CFG_IDX_W-1:0] CFG_PRG_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHR_COUNT = 2'd1;

  localparam logic [5:0] PRG_COUNT_RESET = 6'd2;
  localparam logic [4:0] CHR_COUNT_RESET = 5'd0;

  localparam logic [1:0] FUNC_CPU_WR = 2'd0;
  localparam logic [1:0] FUNC_CPU_RD = 2'd1;
  localparam logic [1:0] FUNC_PPU_RD = 2'd2;
  localparam logic [1:0] FUNC_PPU_WR = 2'd3;

  localparam logic [15:0] ADDR_PRG_BASE  = 16'h8000;
  localparam logic [15:0] ADDR_PRG_UPPER = 16'hC000;
  localparam logic [15:0] ADDR_CHR_TOP   = 16'h1FFF;
  localparam logic [15:0] ADDR_CHR_UPPER = 16'h1000;

  localparam logic [4:0] SHIFT_MARK  = 5'h10;
  localparam logic [4:0] CTRL_RESET  = 5'h0C;
  localparam logic [4:0] CTRL_PRG_M3 = 5'h0C;

  // remainder unit: dividend padded to 6 bits, 3 bits per cycle
  localparam int unsigned REM_DVD_W     = 6;
  localparam int unsigned REM_BITS_STEP = 3;
  localparam int unsigned REM_STEPS     = REM_DVD_W / REM_BITS_STEP;

  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] address;
    logic [7:0]  data;
    logic [15:0] write_stamp;
  } bmap_in_t;

  typedef struct packed {
    logic        mapped;
    logic [18:0] mapped_address;
    logic [1:0]  mirroring;
  } bmap_out_t;

  typedef struct packed {
    logic capture;
    logic prep;
    logic load_out;
  } bmap_cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_done;
  } bmap_sts_t;

endpackage

`default_nettype wire

>>> design/bmap_rem.sv
// iterative remainder unit, restoring form, three quotient bits per cycle
// depends on bmap_pkg
`default_nettype none

module bmap_rem (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start_i,
  input  wire logic [4:0] dividend_i,
  input  wire logic [5:0] divisor_i,
  output logic            done_o,
  output logic [4:0]      remainder_o
);
  import bmap_pkg::*;

  localparam int unsigned CntW = (REM_STEPS > 1) ? $clog2(REM_STEPS) : 1;

  logic [5:0]           rem_q, rem_d;
  logic [REM_DVD_W-1:0] dvd_q, dvd_d;
  logic [5:0]           dsr_q;
  logic [CntW-1:0]      cnt_q;
  logic                 busy_q;
  logic                 done_q;

  always_comb begin
    logic [6:0] t;
    t     = '0;
    rem_d = rem_q;
    dvd_d = dvd_q;
    for (int i = 0; i < REM_BITS_STEP; i++) begin
      t     = {rem_d, dvd_d[REM_DVD_W-1]};
      dvd_d = {dvd_d[REM_DVD_W-2:0], 1'b0};
      if (t >= {1'b0, dsr_q}) begin
        t = t - {1'b0, dsr_q};
      end
      rem_d = t[5:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(REM_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dvd_q <= REM_DVD_W'(dividend_i);
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      dvd_q <= dvd_d;
    end
  end

  assign done_o      = done_q;
  assign remainder_o = rem_q[4:0];

endmodule

`default_nettype wire

>>> design/bmap_dp.sv
// bank mapper datapath: config and bank registers, serial loader, offset build
// depends on bmap_pkg and bmap_rem
`default_nettype none

module bmap_dp #(
  parameter int unsigned StampBits = bmap_pkg::STAMP_BITS_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire bmap_pkg::bmap_cmd_t            cmd_i,
  output bmap_pkg::bmap_sts_t                 sts_o,
  input  wire bmap_pkg::bmap_in_t             in_data_i,
  output bmap_pkg::bmap_out_t                 out_data_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [bmap_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [bmap_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import bmap_pkg::*;

  localparam logic [1:0] REG_CONTROL = 2'd0;
  localparam logic [1:0] REG_CHR_LO  = 2'd1;
  localparam logic [1:0] REG_CHR_HI  = 2'd2;
  localparam logic [1:0] REG_PRG     = 2'd3;

  bmap_in_t       item_q;
  bmap_out_t      out_q;
  logic [5:0]     prg_cnt_q;
  logic [4:0]     chr_cnt_q;
  logic [4:0]     shift_q, ctrl_q, chr_lo_q, chr_hi_q, prg_q;
  logic           have_prior_q;
  logic [StampBits-1:0] prior_q;

  logic [StampBits-1:0] stamp_m;
  logic       is_wr, is_cpu_rd, prg_hit, chr_hit, acc_mapped, wr_take;
  logic [5:0] prg_total, chr_count;
  logic       prg_full;
  logic [4:0] half, outer, sel_lo, sel_hi, prg_sel, chr_dvd;
  logic [4:0] dvd, rem, prg_bank, next_shift;
  logic [5:0] dsr, pair1, chr_bank;
  logic       div_done;
  bmap_out_t  res;

  always_comb begin
    stamp_m   = StampBits'(item_q.write_stamp);
    is_wr     = item_q.func == FUNC_CPU_WR;
    is_cpu_rd = item_q.func == FUNC_CPU_RD;
    prg_hit   = is_cpu_rd && (item_q.address >= ADDR_PRG_BASE);
    chr_hit   = !is_wr && !is_cpu_rd && (item_q.address <= ADDR_CHR_TOP) &&
                ((item_q.func == FUNC_PPU_RD) || (chr_cnt_q == 5'd0));
    acc_mapped = prg_hit || chr_hit;
    wr_take   = is_wr && (item_q.address >= ADDR_PRG_BASE) &&
                !(have_prior_q && (stamp_m == prior_q));

    if (prg_cnt_q == 6'd0) begin
      prg_total = 6'd1;
    end else if (prg_cnt_q > 6'd32) begin
      prg_total = 6'd32;
    end else begin
      prg_total = prg_cnt_q;
    end
    prg_full = prg_total == 6'd32;
    half     = prg_full ? 5'd16 : prg_total[4:0];
    outer    = (prg_full && chr_lo_q[4]) ? 5'd16 : 5'd0;

    unique case (ctrl_q[3:2])
      2'd0, 2'd1: begin
        sel_lo = {1'b0, prg_q[3:1], 1'b0};
        sel_hi = {1'b0, prg_q[3:1], 1'b1};
      end
      2'd2: begin
        sel_lo = 5'd0;
        sel_hi = {1'b0, prg_q[3:0]};
      end
      default: begin
        sel_lo = {1'b0, prg_q[3:0]};
        sel_hi = half - 5'd1;
      end
    endcase
    prg_sel = (item_q.address >= ADDR_PRG_UPPER) ? sel_hi : sel_lo;

    chr_count = (chr_cnt_q == 5'd0) ? 6'd2 : {chr_cnt_q, 1'b0};
    if (ctrl_q[4]) begin
      chr_dvd = (item_q.address >= ADDR_CHR_UPPER) ? chr_hi_q : chr_lo_q;
    end else begin
      chr_dvd = {chr_lo_q[4:1], 1'b0};
    end

    dvd = is_cpu_rd ? prg_sel : chr_dvd;
    dsr = is_cpu_rd ? {1'b0, half} : chr_count;

    prg_bank = outer + rem;
    pair1    = {1'b0, rem} + 6'd1;
    if (!ctrl_q[4] && (item_q.address >= ADDR_CHR_UPPER)) begin
      chr_bank = (pair1 == chr_count) ? 6'd0 : pair1;
    end else begin
      chr_bank = {1'b0, rem};
    end

    res.mapped    = acc_mapped;
    res.mirroring = ctrl_q[1:0];
    if (prg_hit) begin
      res.mapped_address = {prg_bank, item_q.address[13:0]};
    end else if (chr_hit) begin
      res.mapped_address = {1'b0, chr_bank, item_q.address[11:0]};
    end else begin
      res.mapped_address = '0;
    end

    next_shift = {item_q.data[0], shift_q[4:1]};
  end

  bmap_rem u_rem (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (cmd_i.prep && acc_mapped),
    .dividend_i  (dvd),
    .divisor_i   (dsr),
    .done_o      (div_done),
    .remainder_o (rem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prg_cnt_q    <= PRG_COUNT_RESET;
      chr_cnt_q    <= CHR_COUNT_RESET;
      shift_q      <= SHIFT_MARK;
      ctrl_q       <= CTRL_RESET;
      chr_lo_q     <= '0;
      chr_hi_q     <= '0;
      prg_q        <= '0;
      have_prior_q <= 1'b0;
      prior_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_PRG_COUNT) begin
          prg_cnt_q <= cfg_data_i;
        end else if (cfg_index_i == CFG_CHR_COUNT) begin
          chr_cnt_q <= cfg_data_i[4:0];
        end
      end
      if (cmd_i.prep && wr_take) begin
        have_prior_q <= 1'b1;
        prior_q      <= stamp_m;
        if (item_q.data[7]) begin
          shift_q <= SHIFT_MARK;
          ctrl_q  <= ctrl_q | CTRL_PRG_M3;
        end else if (shift_q[0]) begin
          shift_q <= SHIFT_MARK;
          unique case (item_q.address[14:13])
            REG_CONTROL: ctrl_q   <= next_shift;
            REG_CHR_LO:  chr_lo_q <= next_shift;
            REG_CHR_HI:  chr_hi_q <= next_shift;
            REG_PRG:     prg_q    <= next_shift;
            default:     prg_q    <= next_shift;
          endcase
        end else begin
          shift_q <= next_shift;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_q <= in_data_i;
    end
    if (cmd_i.load_out) begin
      out_q <= res;
    end
  end

  assign sts_o.need_div = acc_mapped;
  assign sts_o.div_done = div_done;
  assign out_data_o     = out_q;

endmodule

`default_nettype wire

>>> design/bmap_ctrl.sv
// bank mapper controller: item sequencing and output register handshake
// depends on bmap_pkg
`default_nettype none

module bmap_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output bmap_pkg::bmap_cmd_t      cmd_o,
  input  wire bmap_pkg::bmap_sts_t sts_i
);
  import bmap_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_DONE
  } state_e;

  state_e state_q;
  logic   out_valid_q;

  assign in_ready_o     = state_q == ST_IDLE;
  assign out_valid_o    = out_valid_q;
  assign cmd_o.capture  = in_valid_i && in_ready_o;
  assign cmd_o.prep     = state_q == ST_PREP;
  assign cmd_o.load_out = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (cmd_o.capture) begin
            state_q <= ST_PREP;
          end
        end
        ST_PREP: begin
          state_q <= sts_i.need_div ? ST_DIV : ST_DONE;
        end
        ST_DIV: begin
          if (sts_i.div_done) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (cmd_o.load_out) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // a transfer in always starts the preparation cycle
  a_capture_prep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> state_q == ST_PREP)
    else $error("item accepted without prep cycle");

  a_div_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> ($past(state_q) == ST_PREP || $past(state_q) == ST_DIV))
    else $error("remainder wait entered out of order");

  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.div_done |-> state_q == ST_DIV)
    else $error("remainder done outside wait state");

  a_load_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |=> out_valid_q && state_q == ST_IDLE)
    else $error("result load lost");

endmodule

`default_nettype wire

>>> design/serial_loaded_bank_mapper.sv
// serially loaded bank mapper, top level: controller plus datapath
// steps: a cpu write or unmapped access goes through prep and load; a mapped access goes
// through prep, the 3-bit-per-cycle remainder unit, its registered done flag and load
// one item in flight; next input taken the cycle after the result is registered, and
// the result load waits while the output is stalled
// reset: asynchronous active-low; bank registers and config return to power-up values at once
`default_nettype none

module serial_loaded_bank_mapper #(
  parameter int unsigned StampBits = bmap_pkg::STAMP_BITS_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire bmap_pkg::bmap_in_t              in_data_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output bmap_pkg::bmap_out_t                  out_data_o,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [bmap_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [bmap_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import bmap_pkg::*;

  bmap_cmd_t cmd;
  bmap_sts_t sts;

  assign cfg_ready_o = 1'b1;

  bmap_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  bmap_dp #(
    .StampBits (StampBits)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (in_data_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

endmodule

`default_nettype wire

>>> tb/tb_serial_loaded_bank_mapper.sv
// testbench for serial_loaded_bank_mapper: drives bus accesses with random gaps and config writes
// after draining, predicts every result in a scoreboard class and compares it on transfer
// depends on bmap_pkg and the serial_loaded_bank_mapper rtl
`default_nettype none

module tb_serial_loaded_bank_mapper;
  import bmap_pkg::*;

  localparam int unsigned IdleLimit = 2000;
  localparam int unsigned MaxReports = 10;

  localparam logic [1:0] SEL_CONTROL = 2'd0;
  localparam logic [1:0] SEL_CHR_LO  = 2'd1;
  localparam logic [1:0] SEL_CHR_HI  = 2'd2;
  localparam logic [1:0] SEL_PRG     = 2'd3;

  localparam logic [1:0] PRG_32K_EVEN  = 2'd0;
  localparam logic [1:0] PRG_32K_ODD   = 2'd1;
  localparam logic [1:0] PRG_FIX_FIRST = 2'd2;
  localparam logic [1:0] PRG_FIX_LAST  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  localparam int unsigned PRG_BANK_BYTES  = 16 * 1024;
  localparam int unsigned CHR_BANK_BYTES  = 4 * 1024;
  localparam logic [15:0] PRG_WINDOW_MASK = 16'h3FFF;
  localparam logic [15:0] CHR_WINDOW_MASK = 16'h0FFF;

  class map_checker;
    logic [5:0]  prg_count;
    logic [4:0]  chr_count;
    logic [4:0]  shifter;
    logic [4:0]  ctrl;
    logic [4:0]  chr_lo;
    logic [4:0]  chr_hi;
    logic [4:0]  prg_bank;
    bit          seen_write;
    logic [15:0] last_stamp;
    bmap_out_t   due_results[$];
    int unsigned mismatches;
    int unsigned n_checked;
    int unsigned n_loads;
    int unsigned n_resets;
    int unsigned n_dropped;

    function new();
      prg_count  = PRG_COUNT_RESET;
      chr_count  = CHR_COUNT_RESET;
      shifter    = SHIFT_MARK;
      ctrl       = CTRL_RESET;
      chr_lo     = '0;
      chr_hi     = '0;
      prg_bank   = '0;
      seen_write = 1'b0;
      last_stamp = '0;
      mismatches = 0;
      n_checked  = 0;
      n_loads    = 0;
      n_resets   = 0;
      n_dropped  = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      if (idx == CFG_PRG_COUNT) prg_count = val;
      else if (idx == CFG_CHR_COUNT) chr_count = val[4:0];
    endfunction

    function int unsigned prg_base(bit upper);
      int unsigned total, half, outer, bank, lo, hi, sel;
      total = prg_count;
      if (total == 0) total = 1;
      if (total > 32) total = 32;
      half  = (total >= 32) ? 16 : total;
      outer = (total >= 32 && chr_lo[4]) ? 16 : 0;
      bank  = prg_bank[3:0];
      case (ctrl[3:2])
        PRG_32K_EVEN, PRG_32K_ODD: begin
          lo = {bank[3:1], 1'b0};
          hi = lo + 1;
        end
        PRG_FIX_FIRST: begin
          lo = 0;
          hi = bank;
        end
        default: begin
          lo = bank;
          hi = half - 1;
        end
      endcase
      sel = upper ? hi : lo;
      return ((outer + sel % half) % total) * PRG_BANK_BYTES;
    endfunction

    function int unsigned chr_base(bit upper);
      int unsigned count, pair;
      count = (chr_count == 0) ? 2 : chr_count * 2;
      if (ctrl[4]) return ((upper ? chr_hi : chr_lo) % count) * CHR_BANK_BYTES;
      pair = {chr_lo[4:1], 1'b0} % count;
      if (upper) pair = (pair + 1) % count;
      return pair * CHR_BANK_BYTES;
    endfunction

    function void cpu_write(logic [15:0] addr, logic [7:0] data, logic [15:0] stamp);
      bit full;
      if (addr < ADDR_PRG_BASE) return;
      if (seen_write && stamp == last_stamp) begin
        n_dropped++;
        return;
      end
      seen_write = 1'b1;
      last_stamp = stamp;
      if (data[7]) begin
        shifter = SHIFT_MARK;
        ctrl    = ctrl | CTRL_PRG_M3;
        n_resets++;
        return;
      end
      full    = shifter[0];
      shifter = {data[0], shifter[4:1]};
      if (full) begin
        case (addr[14:13])
          SEL_CONTROL: ctrl   = shifter;
          SEL_CHR_LO:  chr_lo = shifter;
          SEL_CHR_HI:  chr_hi = shifter;
          default:     prg_bank = shifter;
        endcase
        shifter = SHIFT_MARK;
        n_loads++;
      end
    endfunction

    function void note_access(bmap_in_t it);
      bmap_out_t   r;
      int unsigned where;
      r = '0;
      where = 0;
      case (it.func)
        FUNC_CPU_WR: cpu_write(it.address, it.data, it.write_stamp);
        FUNC_CPU_RD: begin
          if (it.address >= ADDR_PRG_BASE) begin
            r.mapped = 1'b1;
            where = prg_base(it.address >= ADDR_PRG_UPPER) + (it.address & PRG_WINDOW_MASK);
          end
        end
        default: begin
          if (it.address <= ADDR_CHR_TOP && (it.func == FUNC_PPU_RD || chr_count == 0)) begin
            r.mapped = 1'b1;
            where = chr_base(it.address >= ADDR_CHR_UPPER) + (it.address & CHR_WINDOW_MASK);
          end
        end
      endcase
      r.mapped_address = where[18:0];
      r.mirroring      = ctrl[1:0];
      due_results.push_back(r);
    endfunction

    function void check_result(bmap_out_t got);
      bmap_out_t want;
      bit        bad;
      if (due_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("unexpected result with nothing outstanding: mapped=%0b addr=%05h mir=%0d",
                   got.mapped, got.mapped_address, got.mirroring);
        return;
      end
      want = due_results.pop_front();
      n_checked++;
      bad = (got.mapped !== want.mapped) || (got.mapped_address !== want.mapped_address) ||
            (got.mirroring !== want.mirroring);
      if (bad) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("mismatch on result %0d: expected mapped=%0b addr=%05h mir=%0d, got %0b %05h %0d",
                   n_checked, want.mapped, want.mapped_address, want.mirroring,
                   got.mapped, got.mapped_address, got.mirroring);
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  bmap_in_t              in_data = '0;
  logic                  in_ready;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  bmap_out_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  map_checker  sb;
  bit          calm = 1'b0;
  int unsigned n_sent = 0;
  int unsigned n_settings = 0;
  int unsigned idle_cycles = 0;
  int unsigned stall_left = 0;
  int unsigned roll;

  serial_loaded_bank_mapper u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(negedge clk) begin
    if (calm) begin
      out_ready <= 1'b1;
    end else if (stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left = stall_left - 1;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 4) begin
        out_ready <= 1'b0;
        stall_left = $urandom_range(8, 40);
      end else if (roll < 25) begin
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles = idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("timeout: no transfer for %0d cycles", IdleLimit);
        $display("FAIL");
        $finish;
      end
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [15:0] fresh_stamp();
    logic [15:0] s;
    s = 16'($urandom);
    if (sb.seen_write && s == sb.last_stamp) s = s + 16'd1;
    return s;
  endfunction

  task automatic send_item(input bmap_in_t it);
    int unsigned gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_access(it);
    n_sent++;
  endtask

  task automatic issue(input logic [1:0] f, input logic [15:0] a, input logic [7:0] d,
                       input logic [15:0] s);
    bmap_in_t it;
    it.func        = f;
    it.address     = a;
    it.data        = d;
    it.write_stamp = s;
    send_item(it);
  endtask

  task automatic drain_and_settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.due_results.size() != 0) @(posedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_reg(input logic [1:0] sel, input logic [4:0] value);
    for (int i = 0; i < 5; i++)
      issue(FUNC_CPU_WR, {1'b1, sel, 13'($urandom)}, {1'b0, 6'($urandom), value[i]},
            fresh_stamp());
  endtask

  // partial serial load cut short by a reset write, a repeated stamp or a low write
  task automatic broken_load();
    int unsigned k;
    logic [15:0] a;
    k = $urandom_range(1, 4);
    a = {1'b1, 15'($urandom)};
    repeat (k) issue(FUNC_CPU_WR, a, {1'b0, 7'($urandom)}, fresh_stamp());
    case ($urandom_range(0, 2))
      0: issue(FUNC_CPU_WR, {1'b1, 15'($urandom)}, {1'b1, 7'($urandom)}, fresh_stamp());
      1: issue(FUNC_CPU_WR, a, 8'($urandom), sb.last_stamp);
      default: issue(FUNC_CPU_WR, {1'b0, 15'($urandom)}, 8'($urandom), fresh_stamp());
    endcase
  endtask

  task automatic random_access();
    logic [1:0]  f;
    logic [15:0] a;
    case ($urandom_range(0, 2))
      0: f = FUNC_CPU_RD;
      1: f = FUNC_PPU_RD;
      default: f = FUNC_PPU_WR;
    endcase
    if ($urandom_range(0, 6) == 0) a = 16'($urandom);
    else if (f == FUNC_CPU_RD) a = {1'b1, 15'($urandom)};
    else a = {3'b000, 13'($urandom)};
    issue(f, a, 8'($urandom), 16'($urandom));
  endtask

  task automatic run_mix(input int unsigned count);
    int unsigned stop, r;
    stop = n_sent + count;
    while (n_sent < stop) begin
      r = $urandom_range(0, 99);
      if (r < 25) load_reg(2'($urandom), 5'($urandom));
      else if (r < 35) broken_load();
      else if (r < 88) random_access();
      else issue(2'($urandom), 16'($urandom), 8'($urandom), 16'($urandom));
    end
  endtask

  task automatic run_phase(input logic [5:0] prg, input logic [5:0] chr, input bit quiet);
    drain_and_settle();
    if ($urandom_range(0, 1) == 0) begin
      write_cfg(CFG_PRG_COUNT, prg);
      write_cfg(CFG_CHR_COUNT, chr);
    end else begin
      write_cfg(CFG_CHR_COUNT, chr);
      write_cfg(CFG_PRG_COUNT, prg);
    end
    n_settings++;
    calm = quiet;
    run_mix(55);
  endtask

  initial begin
    sb = new();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // power-up settings: prg mode 3, chr ram
    issue(FUNC_CPU_RD, 16'h8000, 8'h00, 16'h0000);
    issue(FUNC_CPU_RD, 16'hBFFF, 8'hFF, 16'hFFFF);
    issue(FUNC_CPU_RD, 16'hC000, 8'h00, 16'h0000);
    issue(FUNC_CPU_RD, 16'hFFFF, 8'hFF, 16'hFFFF);
    issue(FUNC_CPU_RD, 16'h7FFF, 8'h00, 16'h0000);
    issue(FUNC_PPU_RD, 16'h0000, 8'h00, 16'h0000);
    issue(FUNC_PPU_RD, 16'h1FFF, 8'hFF, 16'hFFFF);
    issue(FUNC_PPU_RD, 16'h2000, 8'h00, 16'h0000);
    issue(FUNC_PPU_WR, 16'h0FFF, 8'hFF, 16'hFFFF);
    issue(FUNC_PPU_WR, 16'h2000, 8'h00, 16'h0000);
    issue(FUNC_CPU_WR, 16'h7FFF, 8'hFF, 16'hFFFF);
    // control load with a repeated stamp in the middle
    issue(FUNC_CPU_WR, 16'h8000, 8'h01, 16'h0000);
    issue(FUNC_CPU_WR, 16'h8000, 8'h00, 16'h0000);
    issue(FUNC_CPU_WR, 16'h9FFF, 8'h7F, 16'h0001);
    issue(FUNC_CPU_WR, 16'h8123, 8'h01, 16'h0002);
    issue(FUNC_CPU_WR, 16'h9000, 8'h7F, 16'h0003);
    issue(FUNC_CPU_WR, 16'h8FFF, 8'h01, 16'h0004);
    issue(FUNC_CPU_RD, 16'hC000, 8'h00, 16'h0000);
    issue(FUNC_PPU_RD, 16'h1000, 8'h00, 16'h0000);
    // reset write in the middle of a load
    issue(FUNC_CPU_WR, 16'hE000, 8'h00, 16'h0005);
    issue(FUNC_CPU_WR, 16'hFFFF, 8'hFF, 16'hFFFF);
    load_reg(SEL_PRG, 5'h1F);
    issue(FUNC_CPU_RD, 16'hFFFF, 8'h00, 16'h0000);

    drain_and_settle();
    write_cfg(CFG_SPARE, 6'h3F);

    run_phase(6'd1, 6'd0, 1'b0);
    run_phase(6'd32, 6'd16, 1'b1);
    run_phase(6'd0, 6'h3F, 1'b0);
    run_phase(6'd63, 6'd1, 1'b0);
    run_phase(6'd32, 6'd0, 1'b1);
    run_phase(6'($urandom_range(1, 32)), 6'($urandom_range(0, 16)), 1'b0);
    run_phase(PRG_COUNT_RESET, 6'(CHR_COUNT_RESET), 1'b0);

    drain_and_settle();
    repeat (12) @(posedge clk);

    $display("%0d accesses sent, %0d results checked over %0d bank-count settings",
             n_sent, sb.n_checked, n_settings + 1);
    $display("%0d serial register loads, %0d shift resets, %0d repeated-stamp writes dropped",
             sb.n_loads, sb.n_resets, sb.n_dropped);
    if (sb.due_results.size() != 0)
      $display("%0d results never arrived", sb.due_results.size());
    if (sb.mismatches == 0 && sb.due_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
